>>> design/mcps_pkg.sv
`timescale 1ns / 1ps

package mcps_pkg;

    localparam int DEF_ROWS   = 4;
    localparam int DEF_COLS   = 4;
    localparam int DEF_PERIOD = 32;

    localparam int VAL_W  = 8;
    localparam int CELL_W = 4;
    localparam int ROW_W  = 2;
    localparam int OCOL_W = 4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] target;
        logic [VAL_W-1:0] pval;
        logic [VAL_W-1:0] rem;
    } cell_t;

    typedef struct packed {
        logic latch;
        logic fresh;
        logic pending;
    } mode_t;

endpackage

>>> design/mcps_cell.sv
`timescale 1ns / 1ps

module mcps_cell
    import mcps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [VAL_W-1:0] wr_value,
    input  logic             shift,
    input  cell_t            shift_in,
    output cell_t            data
);

    cell_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (wr_en)
        begin
            data_reg.target <= wr_value;
        end
        else if (shift)
        begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule

>>> design/mcps_decide.sv
`timescale 1ns / 1ps

module mcps_decide
    import mcps_pkg::*;
#(
    parameter int PERIOD = DEF_PERIOD
)
(
    input  cell_t cur,
    input  mode_t mode,
    output cell_t nxt,
    output logic  on
);

    localparam logic [VAL_W-1:0] PER = VAL_W'(PERIOD);

    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] pv;
    logic [VAL_W-1:0] rm;
    logic [VAL_W+1:0] diff;
    logic             pos;
    logic             wrap;

    always_comb
    begin
        t    = cur.target;
        pv   = mode.latch ? cur.target : cur.pval;
        rm   = mode.latch ? cur.target : cur.rem;
        diff = {2'b00, t} - ({2'b00, pv} - {2'b00, rm});
        pos  = !diff[VAL_W+1] && (diff != '0);
        wrap = (rm > PER) && !mode.pending && (t > PER);
        nxt.pval = pv;
        if (mode.fresh)
        begin
            nxt.target = t;
            nxt.rem    = pos ? (diff[VAL_W-1:0] - VAL_W'(1)) : rm;
            on         = pos;
        end
        else
        begin
            nxt.target = wrap ? (t - PER) : t;
            on         = (rm != '0);
            nxt.rem    = on ? (rm - VAL_W'(1)) : rm;
        end
    end

endmodule

>>> design/matrix_cell_pwm_scanner.sv
`timescale 1ns / 1ps

// channel  signals                      transaction
// input    in_valid in_stall            func, cell_req, value
// output   out_valid out_stall          row, columns, last
//
// a write sets the target of one cell; a tick walks all ROWS*COLS cells through
// one decision unit, one cell per cycle while no row end waits on a stalled
// output register; after a tick is accepted the input is stalled until the
// last row has been handed to the output register
// the last row waits in the output register while the next transaction is accepted
// reset clears all cell state, the scan phase and the fresh and pending marks

module matrix_cell_pwm_scanner
    import mcps_pkg::*;
#(
    parameter int ROWS   = DEF_ROWS,
    parameter int COLS   = DEF_COLS,
    parameter int PERIOD = DEF_PERIOD
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [CELL_W-1:0] cell_req,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ROW_W-1:0]  row,
    output logic [OCOL_W-1:0] columns,
    output logic              last
);

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PW    = $clog2(PERIOD);

    typedef enum logic {IDLE, SCAN} state_t;

    state_t            state_reg;
    logic [RW-1:0]     row_cnt_reg;
    logic [CW-1:0]     col_cnt_reg;
    logic [COLS-1:0]   acc_reg;
    logic [PW-1:0]     phase_reg;
    logic              fresh_reg;
    logic              pending_reg;
    logic              out_valid_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [OCOL_W-1:0] columns_reg;
    logic              last_reg;

    cell_t             cell_q [CELLS];
    cell_t             dec_cell;
    logic              dec_on;
    mode_t             mode;
    logic              in_acc;
    logic              step;
    logic              col_last;
    logic              row_last;
    logic [COLS-1:0]   acc_next;
    logic [COLS+OCOL_W-1:0] acc_ext;
    logic [RW+ROW_W-1:0]    row_ext;
    logic              wr_ok;

    assign in_stall = (state_reg != IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign wr_ok    = in_acc && (func == FUNC_WRITE) && (32'(cell_req) < 32'(CELLS));

    assign col_last = (32'(col_cnt_reg) == 32'(COLS - 1));
    assign row_last = (32'(row_cnt_reg) == 32'(ROWS - 1));
    assign step     = (state_reg == SCAN) && !(col_last && out_valid_reg && out_stall);

    assign mode.latch   = (phase_reg == '0);
    assign mode.fresh   = fresh_reg && (phase_reg != '0);
    assign mode.pending = pending_reg && (phase_reg != '0);

    mcps_decide #(
        .PERIOD(PERIOD)
    ) u_decide (
        .cur  (cell_q[0]),
        .mode (mode),
        .nxt  (dec_cell),
        .on   (dec_on)
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        cell_t shift_in;
        if (i == CELLS - 1)
        begin : g_tail
            assign shift_in = dec_cell;
        end
        else
        begin : g_body
            assign shift_in = cell_q[i+1];
        end
        mcps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_ok && (32'(cell_req) == i)),
            .wr_value (value),
            .shift    (step),
            .shift_in (shift_in),
            .data     (cell_q[i])
        );
    end

    assign acc_next = acc_reg | (COLS'(dec_on) << col_cnt_reg);
    assign acc_ext  = (COLS+OCOL_W)'(acc_next);
    assign row_ext  = (RW+ROW_W)'(row_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            acc_reg       <= '0;
            phase_reg     <= '0;
            fresh_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            columns_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !(step && col_last))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (wr_ok)
                    begin
                        fresh_reg   <= 1'b1;
                        pending_reg <= 1'b1;
                    end
                    if (in_acc && (func == FUNC_TICK))
                    begin
                        state_reg   <= SCAN;
                        row_cnt_reg <= '0;
                        col_cnt_reg <= '0;
                        acc_reg     <= '0;
                    end
                end
                SCAN:
                begin
                    if (step)
                    begin
                        if (col_last)
                        begin
                            col_cnt_reg   <= '0;
                            acc_reg       <= '0;
                            out_valid_reg <= 1'b1;
                            row_reg       <= row_ext[ROW_W-1:0];
                            columns_reg   <= acc_ext[OCOL_W-1:0];
                            last_reg      <= row_last;
                            if (row_last)
                            begin
                                state_reg   <= IDLE;
                                row_cnt_reg <= '0;
                                fresh_reg   <= 1'b0;
                                if (mode.latch)
                                begin
                                    pending_reg <= 1'b0;
                                end
                                if (32'(phase_reg) == 32'(PERIOD - 1))
                                begin
                                    phase_reg <= '0;
                                end
                                else
                                begin
                                    phase_reg <= phase_reg + PW'(1);
                                end
                            end
                            else
                            begin
                                row_cnt_reg <= row_cnt_reg + RW'(1);
                            end
                        end
                        else
                        begin
                            col_cnt_reg <= col_cnt_reg + CW'(1);
                            acc_reg     <= acc_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign columns   = columns_reg;
    assign last      = last_reg;

endmodule
